/* hw/rtl/box_iou_cost_top_macros.svh */
// ----------------------------------------------------------------------------
// box_iou_cost_top_macros.svh
// assertion macros for the box iou cost block
// ----------------------------------------------------------------------------
`ifndef BOX_IOU_COST_TOP_MACROS_SVH
`define BOX_IOU_COST_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define BIOU_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BIOU_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BIOU_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg)
`define BIOU_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)

`endif

`endif

/* hw/rtl/biou_pkg.sv */
// ----------------------------------------------------------------------------
// biou_pkg
// shared constants and types of the box iou cost pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package biou_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 15;
  localparam int SLOT_BITS_DEF  = 8;

  // frames-since-update counter width and the gating limit
  localparam int         UNSEEN_BITS = 8;
  localparam logic [7:0] GATE_LIMIT  = 8'd1;

  // control carried along with each item through the pipeline
  typedef struct packed {
    logic valid;
    logic gated;
    logic force_one;
  } biou_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/biou_if.sv */
// ----------------------------------------------------------------------------
// biou_if
// valid/ready channels for box pairs and cost results
// ----------------------------------------------------------------------------
`default_nettype none

interface biou_in_if
  import biou_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SLOT_BITS  = SLOT_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic [SLOT_BITS-1:0]         row_slot;
  logic [SLOT_BITS-1:0]         col_slot;
  logic signed [COORD_BITS-1:0] track_left;
  logic signed [COORD_BITS-1:0] track_top;
  logic [COORD_BITS-2:0]        track_width;
  logic [COORD_BITS-2:0]        track_height;
  logic [UNSEEN_BITS-1:0]       frames_unseen;
  logic signed [COORD_BITS-1:0] det_left;
  logic signed [COORD_BITS-1:0] det_top;
  logic [COORD_BITS-2:0]        det_width;
  logic [COORD_BITS-2:0]        det_height;

  modport source (
    output valid, row_slot, col_slot, track_left, track_top, track_width,
           track_height, frames_unseen, det_left, det_top, det_width, det_height,
    input  ready
  );
  modport sink (
    input  valid, row_slot, col_slot, track_left, track_top, track_width,
           track_height, frames_unseen, det_left, det_top, det_width, det_height,
    output ready
  );
endinterface

interface biou_out_if
  import biou_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SLOT_BITS = SLOT_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [SLOT_BITS-1:0] row_out;
  logic [SLOT_BITS-1:0] col_out;
  logic [FRAC_BITS:0]   cost;
  logic                 gated;

  modport source (output valid, row_out, col_out, cost, gated, input ready);
  modport sink   (input valid, row_out, col_out, cost, gated, output ready);
endinterface

`default_nettype wire

/* hw/rtl/biou_front.sv */
// ----------------------------------------------------------------------------
// biou_front
// overlap extents, the three area products and the union, over three stages
// ----------------------------------------------------------------------------
`default_nettype none

module biou_front
  import biou_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int SLOT_BITS  = SLOT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  biou_in_if.sink                         in_ch,
  input  wire logic                       dn_ready,
  output biou_ctl_t                       dn_ctl,
  output logic [2*COORD_BITS-2:0]         dn_rem,
  output logic [2*COORD_BITS-2:0]         dn_den,
  output logic [FRAC_BITS:0]              dn_q,
  output logic [SLOT_BITS-1:0]            dn_row,
  output logic [SLOT_BITS-1:0]            dn_col
);

  localparam int LEN_BITS  = COORD_BITS - 1;
  localparam int AREA_BITS = 2 * COORD_BITS - 2;
  localparam int UNI_BITS  = 2 * COORD_BITS - 1;

  // clamped overlap of [a_lo, a_lo+a_len) and [b_lo, b_lo+b_len)
  function automatic logic [LEN_BITS-1:0] ovl(
    input logic [COORD_BITS-1:0] a_lo,
    input logic [LEN_BITS-1:0]   a_len,
    input logic [COORD_BITS-1:0] b_lo,
    input logic [LEN_BITS-1:0]   b_len
  );
    logic signed [COORD_BITS:0]   alo, blo, ahi, bhi, lo, hi;
    logic signed [COORD_BITS+1:0] d;
    alo = $signed({a_lo[COORD_BITS-1], a_lo});
    blo = $signed({b_lo[COORD_BITS-1], b_lo});
    ahi = alo + $signed({2'b00, a_len});
    bhi = blo + $signed({2'b00, b_len});
    lo  = (alo > blo) ? alo : blo;
    hi  = (ahi < bhi) ? ahi : bhi;
    d   = $signed({hi[COORD_BITS], hi}) - $signed({lo[COORD_BITS], lo});
    return d[COORD_BITS+1] ? '0 : d[LEN_BITS-1:0];
  endfunction

  // stage 1: overlap extents
  biou_ctl_t            ctl1_r;
  logic [LEN_BITS-1:0]  iw_r, ih_r, tw_r, th_r, dw_r, dh_r;
  logic [SLOT_BITS-1:0] row1_r, col1_r;
  // stage 2: products
  biou_ctl_t            ctl2_r;
  logic [AREA_BITS-1:0] inter_r, at_r, ad_r;
  logic [SLOT_BITS-1:0] row2_r, col2_r;
  // stage 3: union, numerator and first quotient bit
  biou_ctl_t            ctl3_r;
  logic [UNI_BITS-1:0]  rem_r, den_r;
  logic [FRAC_BITS:0]   q_r;
  logic [SLOT_BITS-1:0] row3_r, col3_r;

  logic s1_ready, s2_ready, s3_ready;
  logic gate_nxt;
  logic [UNI_BITS-1:0] uni_nxt, num_nxt;
  logic inter_zero;

  assign s3_ready    = !ctl3_r.valid || dn_ready;
  assign s2_ready    = !ctl2_r.valid || s3_ready;
  assign s1_ready    = !ctl1_r.valid || s2_ready;
  assign in_ch.ready = s1_ready;

  assign gate_nxt   = in_ch.frames_unseen > GATE_LIMIT;
  assign uni_nxt    = {1'b0, at_r} + {1'b0, ad_r} - {1'b0, inter_r};
  assign num_nxt    = uni_nxt - {1'b0, inter_r};
  assign inter_zero = (inter_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else begin
      if (s1_ready) begin
        ctl1_r.valid     <= in_ch.valid;
        ctl1_r.gated     <= gate_nxt;
        ctl1_r.force_one <= gate_nxt;
      end
      if (s2_ready) begin
        ctl2_r <= ctl1_r;
      end
      if (s3_ready) begin
        ctl3_r.valid     <= ctl2_r.valid;
        ctl3_r.gated     <= ctl2_r.gated;
        ctl3_r.force_one <= ctl2_r.force_one || (uni_nxt == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && s1_ready) begin
      iw_r   <= ovl(in_ch.track_left, in_ch.track_width, in_ch.det_left, in_ch.det_width);
      ih_r   <= ovl(in_ch.track_top, in_ch.track_height, in_ch.det_top, in_ch.det_height);
      tw_r   <= in_ch.track_width;
      th_r   <= in_ch.track_height;
      dw_r   <= in_ch.det_width;
      dh_r   <= in_ch.det_height;
      row1_r <= in_ch.row_slot;
      col1_r <= in_ch.col_slot;
    end
    if (ctl1_r.valid && s2_ready) begin
      inter_r <= AREA_BITS'(iw_r * ih_r);
      at_r    <= AREA_BITS'(tw_r * th_r);
      ad_r    <= AREA_BITS'(dw_r * dh_r);
      row2_r  <= row1_r;
      col2_r  <= col1_r;
    end
    if (ctl2_r.valid && s3_ready) begin
      // no overlap means the numerator equals the union: leading bit set
      rem_r  <= inter_zero ? '0 : num_nxt;
      den_r  <= uni_nxt;
      q_r    <= {{FRAC_BITS{1'b0}}, inter_zero};
      row3_r <= row2_r;
      col3_r <= col2_r;
    end
  end

  assign dn_ctl = ctl3_r;
  assign dn_rem = rem_r;
  assign dn_den = den_r;
  assign dn_q   = q_r;
  assign dn_row = row3_r;
  assign dn_col = col3_r;

endmodule

`default_nettype wire

/* hw/rtl/biou_div_step.sv */
// ----------------------------------------------------------------------------
// biou_div_step
// one registered restoring-division step, yields one quotient bit
// ----------------------------------------------------------------------------
`default_nettype none

module biou_div_step
  import biou_pkg::*;
#(
  parameter int REM_BITS  = 2 * COORD_BITS_DEF - 1,
  parameter int Q_BITS    = FRAC_BITS_DEF + 1,
  parameter int SLOT_BITS = SLOT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire biou_ctl_t            up_ctl,
  output logic                      up_ready,
  input  wire logic [REM_BITS-1:0]  up_rem,
  input  wire logic [REM_BITS-1:0]  up_den,
  input  wire logic [Q_BITS-1:0]    up_q,
  input  wire logic [SLOT_BITS-1:0] up_row,
  input  wire logic [SLOT_BITS-1:0] up_col,
  output biou_ctl_t                 dn_ctl,
  input  wire logic                 dn_ready,
  output logic [REM_BITS-1:0]       dn_rem,
  output logic [REM_BITS-1:0]       dn_den,
  output logic [Q_BITS-1:0]         dn_q,
  output logic [SLOT_BITS-1:0]      dn_row,
  output logic [SLOT_BITS-1:0]      dn_col
);

  biou_ctl_t            ctl_r;
  logic [REM_BITS-1:0]  rem_r, den_r;
  logic [Q_BITS-1:0]    q_r;
  logic [SLOT_BITS-1:0] row_r, col_r;

  logic [REM_BITS:0]   shifted, diff;
  logic                ge;
  logic [REM_BITS-1:0] rem_nxt;
  logic [Q_BITS-1:0]   q_nxt;

  assign up_ready = !ctl_r.valid || dn_ready;

  always_comb begin
    shifted = {up_rem, 1'b0};
    diff    = shifted - {1'b0, up_den};
    ge      = shifted >= {1'b0, up_den};
    rem_nxt = ge ? diff[REM_BITS-1:0] : shifted[REM_BITS-1:0];
    q_nxt   = {up_q[Q_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (up_ready) begin
      ctl_r <= up_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ctl.valid && up_ready) begin
      rem_r <= rem_nxt;
      den_r <= up_den;
      q_r   <= q_nxt;
      row_r <= up_row;
      col_r <= up_col;
    end
  end

  assign dn_ctl = ctl_r;
  assign dn_rem = rem_r;
  assign dn_den = den_r;
  assign dn_q   = q_r;
  assign dn_row = row_r;
  assign dn_col = col_r;

endmodule

`default_nettype wire

/* hw/rtl/box_iou_cost_top.sv */
// ----------------------------------------------------------------------------
// box_iou_cost_top
// association cost 1 - IoU between a track box and a detection box
// ----------------------------------------------------------------------------
// usage
//   in_ch  : one item per track/detection pair, boxes as top-left corner plus
//            width and height, the track's frames-since-update count and the
//            matrix row/column of the pair
//   out_ch : one item per input item, in order: echoed row/column, cost in
//            unsigned Q1.FRAC_BITS and the gated flag
//   path   : from input accept to output valid: three front stages (overlap,
//            products, union), one stage per quotient bit after the first,
//            one output register
//   rate   : one item per cycle while out_ch.ready stays high; every stage
//            then takes a new item each cycle
//   gating : frames_unseen above one sets gated and forces cost to 1.0; an
//            empty union also gives 1.0 with gated clear
//   reset  : synchronous, active low; clears all stage valid bits, so items in
//            flight are dropped and the pipeline comes up empty and ready
//   stall  : while out_ch.ready is low, a full stage holds its item once every
//            stage below it is full; empty stages upstream still fill, so
//            in_ch.ready drops only once every stage holds an item
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_iou_cost_top_macros.svh"

module box_iou_cost_top
  import biou_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int SLOT_BITS  = SLOT_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  biou_in_if.sink   in_ch,
  biou_out_if.source out_ch
);

  localparam int UNI_BITS = 2 * COORD_BITS - 1;
  localparam logic [FRAC_BITS:0] COST_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // stage k of these arrays is the item after k division steps; the front
  // already resolves the leading quotient bit
  biou_ctl_t            ctl_s [FRAC_BITS+1];
  logic [FRAC_BITS:0]   rdy_s;
  logic [UNI_BITS-1:0]  rem_s [FRAC_BITS+1];
  logic [UNI_BITS-1:0]  den_s [FRAC_BITS+1];
  logic [FRAC_BITS:0]   q_s   [FRAC_BITS+1];
  logic [SLOT_BITS-1:0] row_s [FRAC_BITS+1];
  logic [SLOT_BITS-1:0] col_s [FRAC_BITS+1];

  // output register
  logic                 out_valid_r;
  logic [SLOT_BITS-1:0] out_row_r, out_col_r;
  logic [FRAC_BITS:0]   out_cost_r;
  logic                 out_gated_r;
  logic [FRAC_BITS:0]   out_cost_nxt;

  // overlap, areas, union and the first quotient bit
  biou_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .SLOT_BITS  (SLOT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_ready (rdy_s[0]),
    .dn_ctl   (ctl_s[0]),
    .dn_rem   (rem_s[0]),
    .dn_den   (den_s[0]),
    .dn_q     (q_s[0]),
    .dn_row   (row_s[0]),
    .dn_col   (col_s[0])
  );

  // one fractional quotient bit per stage
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    biou_div_step #(
      .REM_BITS  (UNI_BITS),
      .Q_BITS    (FRAC_BITS + 1),
      .SLOT_BITS (SLOT_BITS)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_ctl   (ctl_s[k]),
      .up_ready (rdy_s[k]),
      .up_rem   (rem_s[k]),
      .up_den   (den_s[k]),
      .up_q     (q_s[k]),
      .up_row   (row_s[k]),
      .up_col   (col_s[k]),
      .dn_ctl   (ctl_s[k+1]),
      .dn_ready (rdy_s[k+1]),
      .dn_rem   (rem_s[k+1]),
      .dn_den   (den_s[k+1]),
      .dn_q     (q_s[k+1]),
      .dn_row   (row_s[k+1]),
      .dn_col   (col_s[k+1])
    );
  end

  // last stage drains into the output register when it is free or taken
  assign rdy_s[FRAC_BITS] = !out_valid_r || out_ch.ready;

  // gated track or empty union: cost pinned to 1.0
  assign out_cost_nxt = ctl_s[FRAC_BITS].force_one ? COST_ONE : q_s[FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_s[FRAC_BITS]) begin
      out_valid_r <= ctl_s[FRAC_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_s[FRAC_BITS].valid && rdy_s[FRAC_BITS]) begin
      out_row_r   <= row_s[FRAC_BITS];
      out_col_r   <= col_s[FRAC_BITS];
      out_cost_r  <= out_cost_nxt;
      out_gated_r <= ctl_s[FRAC_BITS].gated;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.row_out = out_row_r;
  assign out_ch.col_out = out_col_r;
  assign out_ch.cost    = out_cost_r;
  assign out_ch.gated   = out_gated_r;

  // an empty output register means every stage can take an item
  `BIOU_ASSERT_IMPL(a_ready_when_drained, clk, rst_n, !out_valid_r, in_ch.ready, "input stalled with output register empty")
  // cost never exceeds one
  `BIOU_ASSERT_IMPL(a_cost_bound, clk, rst_n, out_valid_r, out_cost_r <= COST_ONE, "cost above 1.0")
  // a gated item always carries the full cost
  `BIOU_ASSERT_IMPL(a_gated_cost, clk, rst_n, out_valid_r && out_gated_r, out_cost_r == COST_ONE, "gated item without full cost")
  // an item leaving the last division stage lands in the output register
  `BIOU_ASSERT_NEXT(a_drain_lands, clk, rst_n, ctl_s[FRAC_BITS].valid && rdy_s[FRAC_BITS], out_valid_r, "item lost at output register")

endmodule

`default_nettype wire
